/* rtl/text_mode_terminal_writer_assert.svh */
// assertion macros for the text mode terminal writer
`ifndef TEXT_MODE_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_MODE_TERMINAL_WRITER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TMTW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TMTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tmtw_pkg.sv */
// shared constants and types for the text mode terminal writer
package tmtw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;
    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int RROW_W = 5;
    localparam int RCOL_W = 7;
    localparam int POS_W  = 11;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NL = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_BS = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } addr_req_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [CELL_W-1:0] wr_data;
    } ram_req_t;

endpackage

/* rtl/text_mode_terminal_writer.sv */
// Text mode terminal writer: a ROWS x COLUMNS (25 x 80) grid of 16-bit cells
// with a cursor, driven by put, clear and read items over valid/ready, one
// result per item. Rows are kept in a ring with one valid bit per row, so
// reset, clear and scroll take effect at once and there is no clearing pass
// after reset. An item is accepted only while the sequencer is idle; from
// acceptance it passes the map, execute and done states for clear, control
// bytes, unused codes, reads outside the grid, puts into a row already written
// and reads of a blank row; a read of a written row adds a read-data state, and
// the first put into a row after reset, clear or scroll adds a fill state, in
// which the cell memory's one write port blanks that row one cell per cycle.
// The result waits in an output register while the next item is taken.
// Attribute writes take effect at once.
module text_mode_terminal_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tmtw_pkg::FUNC_W-1:0]   func,
    input  logic [tmtw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tmtw_pkg::RROW_W-1:0]   read_row,
    input  logic [tmtw_pkg::RCOL_W-1:0]   read_col,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tmtw_pkg::ATTR_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tmtw_pkg::CELL_W-1:0]   cell_value,
    output logic [tmtw_pkg::RROW_W-1:0]   cursor_row,
    output logic [tmtw_pkg::RCOL_W-1:0]   cursor_col,
    output logic [tmtw_pkg::POS_W-1:0]    cursor_position
);

    tmtw_pkg::addr_req_t           addr_req;
    tmtw_pkg::ram_req_t            ram_req;
    logic [tmtw_pkg::ADDR_W-1:0]   addr;
    logic [tmtw_pkg::CELL_W-1:0]   rd_data;

    tmtw_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .char_code       (char_code),
        .read_row        (read_row),
        .read_col        (read_col),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cell_value      (cell_value),
        .cursor_row      (cursor_row),
        .cursor_col      (cursor_col),
        .cursor_position (cursor_position),
        .addr_req        (addr_req),
        .addr            (addr),
        .ram_req         (ram_req),
        .rd_data         (rd_data)
    );

    tmtw_addr_unit u_addr (
        .req  (addr_req),
        .addr (addr)
    );

    tmtw_ram #(
        .WIDTH (tmtw_pkg::CELL_W),
        .DEPTH (tmtw_pkg::CELLS)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

endmodule

/* rtl/tmtw_ram.sv */
// generic single write port ram with registered read
module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/tmtw_addr_unit.sv */
// shared row times columns plus column address unit
module tmtw_addr_unit (
    input  tmtw_pkg::addr_req_t          req,
    output logic [tmtw_pkg::ADDR_W-1:0]  addr
);

    localparam int AW = tmtw_pkg::ADDR_W;

    assign addr = AW'(AW'(req.row) * AW'(tmtw_pkg::COLUMNS)) + AW'(req.col);

endmodule

/* rtl/tmtw_seq.sv */
// sequencer: cursor, row ring, row valid bits, cell access and result register
module tmtw_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tmtw_pkg::FUNC_W-1:0]   func,
    input  logic [tmtw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tmtw_pkg::RROW_W-1:0]   read_row,
    input  logic [tmtw_pkg::RCOL_W-1:0]   read_col,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tmtw_pkg::ATTR_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tmtw_pkg::CELL_W-1:0]   cell_value,
    output logic [tmtw_pkg::RROW_W-1:0]   cursor_row,
    output logic [tmtw_pkg::RCOL_W-1:0]   cursor_col,
    output logic [tmtw_pkg::POS_W-1:0]    cursor_position,
    output tmtw_pkg::addr_req_t           addr_req,
    input  logic [tmtw_pkg::ADDR_W-1:0]   addr,
    output tmtw_pkg::ram_req_t            ram_req,
    input  logic [tmtw_pkg::CELL_W-1:0]   rd_data
);

    localparam int ROWS    = tmtw_pkg::ROWS;
    localparam int COLUMNS = tmtw_pkg::COLUMNS;
    localparam int ROW_W   = tmtw_pkg::ROW_W;
    localparam int COL_W   = tmtw_pkg::COL_W;
    localparam int SUM_W   = ROW_W + 1;
    localparam int CELL_W  = tmtw_pkg::CELL_W;
    localparam int RROW_W  = tmtw_pkg::RROW_W;
    localparam int RCOL_W  = tmtw_pkg::RCOL_W;
    localparam int POS_W   = tmtw_pkg::POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAP   = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_RDATA = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [ROW_W-1:0]              cur_row_reg, cur_row_next;
    logic [COL_W-1:0]              cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]              top_reg, top_next;
    logic [ROWS-1:0]               row_valid_reg, row_valid_next;
    logic [tmtw_pkg::ATTR_W-1:0]   attr_reg, attr_next;
    logic                          out_valid_reg, out_valid_next;

    logic [tmtw_pkg::FUNC_W-1:0]   func_reg, func_next;
    logic [tmtw_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic [RROW_W-1:0]             rrow_reg, rrow_next;
    logic [RCOL_W-1:0]             rcol_reg, rcol_next;
    logic [ROW_W-1:0]              phys_reg, phys_next;
    logic [COL_W-1:0]              sweep_reg, sweep_next;
    logic [CELL_W-1:0]             cell_reg, cell_next;
    logic [CELL_W-1:0]             out_cell_reg, out_cell_next;
    logic [RROW_W-1:0]             out_row_reg, out_row_next;
    logic [RCOL_W-1:0]             out_col_reg, out_col_next;
    logic [POS_W-1:0]              out_pos_reg, out_pos_next;

    logic [ROW_W-1:0]              sel_row;
    logic [SUM_W-1:0]              ring_sum;
    logic                          do_nl;
    logic                          do_adv;
    logic                          wrap;
    logic                          read_in_range;

    assign in_ready        = (state_reg == S_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign cell_value      = out_cell_reg;
    assign cursor_row      = out_row_reg;
    assign cursor_col      = out_col_reg;
    assign cursor_position = out_pos_reg;

    assign sel_row  = (func_reg == tmtw_pkg::FUNC_READ) ? ROW_W'(rrow_reg) : cur_row_reg;
    assign ring_sum = SUM_W'(top_reg) + SUM_W'(sel_row);
    assign read_in_range = (int'(rrow_reg) < ROWS) && (int'(rcol_reg) < COLUMNS);

    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        attr_next      = attr_reg;
        out_valid_next = out_valid_reg;
        func_next      = func_reg;
        char_next      = char_reg;
        rrow_next      = rrow_reg;
        rcol_next      = rcol_reg;
        phys_next      = phys_reg;
        sweep_next     = sweep_reg;
        cell_next      = cell_reg;
        out_cell_next  = out_cell_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_pos_next   = out_pos_reg;
        addr_req.row   = phys_reg;
        addr_req.col   = cur_col_reg;
        ram_req        = '0;
        do_nl          = 1'b0;
        do_adv         = 1'b0;

        if (cfg_valid)
        begin
            attr_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    char_next  = char_code;
                    rrow_next  = read_row;
                    rcol_next  = read_col;
                    cell_next  = '0;
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                // logical row to physical row through the scroll ring
                if (ring_sum >= SUM_W'(ROWS))
                begin
                    phys_next = ROW_W'(ring_sum - SUM_W'(ROWS));
                end
                else
                begin
                    phys_next = ROW_W'(ring_sum);
                end
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (func_reg)
                    tmtw_pkg::FUNC_PUT:
                    begin
                        if (char_reg == tmtw_pkg::CHAR_NL)
                        begin
                            do_nl = 1'b1;
                        end
                        else if (char_reg == tmtw_pkg::CHAR_BS)
                        begin
                            if (cur_col_reg != '0)
                            begin
                                cur_col_next = cur_col_reg - COL_W'(1);
                            end
                        end
                        else if (char_reg == tmtw_pkg::CHAR_CR)
                        begin
                            cur_col_next = '0;
                        end
                        else if (row_valid_reg[phys_reg])
                        begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_data = {attr_reg, char_reg};
                            do_adv          = 1'b1;
                        end
                        else
                        begin
                            // row not yet written: blank it while placing the char
                            sweep_next = '0;
                            state_next = S_FILL;
                        end
                    end
                    tmtw_pkg::FUNC_CLEAR:
                    begin
                        row_valid_next = '0;
                        top_next       = '0;
                        cur_row_next   = '0;
                        cur_col_next   = '0;
                    end
                    tmtw_pkg::FUNC_READ:
                    begin
                        if (read_in_range)
                        begin
                            if (row_valid_reg[phys_reg])
                            begin
                                addr_req.col  = COL_W'(rcol_reg);
                                ram_req.rd_en = 1'b1;
                                state_next    = S_RDATA;
                            end
                            else
                            begin
                                cell_next = tmtw_pkg::BLANK_CELL;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FILL:
            begin
                addr_req.col  = sweep_reg;
                ram_req.wr_en = 1'b1;
                if (sweep_reg == cur_col_reg)
                begin
                    ram_req.wr_data = {attr_reg, char_reg};
                end
                else
                begin
                    ram_req.wr_data = tmtw_pkg::BLANK_CELL;
                end
                if (sweep_reg == COL_W'(COLUMNS - 1))
                begin
                    row_valid_next[phys_reg] = 1'b1;
                    do_adv                   = 1'b1;
                    state_next               = S_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + COL_W'(1);
                end
            end
            S_RDATA:
            begin
                cell_next  = rd_data;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                addr_req.row = cur_row_reg;
                addr_req.col = cur_col_reg;
                if (!out_valid_reg || out_ready)
                begin
                    out_cell_next  = cell_reg;
                    out_row_next   = RROW_W'(cur_row_reg);
                    out_col_next   = RCOL_W'(cur_col_reg);
                    out_pos_next   = POS_W'(addr);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        wrap = do_adv && (cur_col_reg == COL_W'(COLUMNS - 1));

        if (do_adv && !wrap)
        begin
            cur_col_next = cur_col_reg + COL_W'(1);
        end

        // next row; on the bottom row the ring turns and the old top row goes blank
        if (do_nl || wrap)
        begin
            cur_col_next = '0;
            if (cur_row_reg == ROW_W'(ROWS - 1))
            begin
                row_valid_next[top_reg] = 1'b0;
                if (top_reg == ROW_W'(ROWS - 1))
                begin
                    top_next = '0;
                end
                else
                begin
                    top_next = top_reg + ROW_W'(1);
                end
            end
            else
            begin
                cur_row_next = cur_row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            top_reg       <= '0;
            row_valid_reg <= '0;
            attr_reg      <= tmtw_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            top_reg       <= top_next;
            row_valid_reg <= row_valid_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        char_reg     <= char_next;
        rrow_reg     <= rrow_next;
        rcol_reg     <= rcol_next;
        phys_reg     <= phys_next;
        sweep_reg    <= sweep_next;
        cell_reg     <= cell_next;
        out_cell_reg <= out_cell_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_pos_reg  <= out_pos_next;
    end

endmodule

/* rtl/tmtw_checker.sv */
// port level checks for the text mode terminal writer, bound to the top level
`include "text_mode_terminal_writer_assert.svh"

module tmtw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tmtw_pkg::CELL_W-1:0]   cell_value,
    input logic [tmtw_pkg::RROW_W-1:0]   cursor_row,
    input logic [tmtw_pkg::RCOL_W-1:0]   cursor_col,
    input logic [tmtw_pkg::POS_W-1:0]    cursor_position
);

    localparam int PW = tmtw_pkg::POS_W;

    `TMTW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cell_value) && $stable(cursor_position), "result changed while stalled")

    `TMTW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted while busy")

    `TMTW_ASSERT_IMPLY(a_col_range, out_valid, int'(cursor_col) < tmtw_pkg::COLUMNS && int'(cursor_row) < tmtw_pkg::ROWS, "cursor outside grid")

    `TMTW_ASSERT_IMPLY(a_pos_match, out_valid, cursor_position == PW'(PW'(cursor_row) * PW'(tmtw_pkg::COLUMNS) + PW'(cursor_col)), "cursor position mismatch")

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (.*);

/* dv/tb.sv */
// testbench for the text mode terminal writer: directed and random items against a grid model
`timescale 1ns / 100ps

module tb;
    import tmtw_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int PHASE_ITEMS    = 530;

    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic [RROW_W-1:0] row;
        logic [RCOL_W-1:0] col;
        logic [POS_W-1:0]  pos;
    } term_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [FUNC_W-1:0] func = '0;
    logic [CHAR_W-1:0] char_code = '0;
    logic [RROW_W-1:0] read_row = '0;
    logic [RCOL_W-1:0] read_col = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ATTR_W-1:0] cfg_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CELL_W-1:0] cell_value;
    logic [RROW_W-1:0] cursor_row;
    logic [RCOL_W-1:0] cursor_col;
    logic [POS_W-1:0] cursor_position;

    logic [CELL_W-1:0] screen_cells [CELLS];
    int unsigned cur_row;
    int unsigned cur_col;
    logic [ATTR_W-1:0] print_attr;
    term_result_t expected_results [$];

    int unsigned items_sent = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    text_mode_terminal_writer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .char_code       (char_code),
        .read_row        (read_row),
        .read_col        (read_col),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cell_value      (cell_value),
        .cursor_row      (cursor_row),
        .cursor_col      (cursor_col),
        .cursor_position (cursor_position)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function void blank_screen();
        int unsigned i;
        for (i = 0; i < CELLS; i++)
        begin
            screen_cells[i] = BLANK_CELL;
        end
    endfunction

    function void line_feed();
        int unsigned i;
        cur_col = 0;
        if (cur_row + 1 >= ROWS)
        begin
            cur_row = ROWS - 1;
            for (i = 0; i < CELLS - COLUMNS; i++)
            begin
                screen_cells[i] = screen_cells[i + COLUMNS];
            end
            for (i = CELLS - COLUMNS; i < CELLS; i++)
            begin
                screen_cells[i] = BLANK_CELL;
            end
        end
        else
        begin
            cur_row++;
        end
    endfunction

    function term_result_t apply_item(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                                      input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
        term_result_t r;
        r.cell_data = '0;
        case (f)
            FUNC_PUT:
            begin
                if (ch == CHAR_NL)
                begin
                    line_feed();
                end
                else if (ch == CHAR_BS)
                begin
                    if (cur_col > 0)
                    begin
                        cur_col--;
                    end
                end
                else if (ch == CHAR_CR)
                begin
                    cur_col = 0;
                end
                else
                begin
                    screen_cells[cur_row * COLUMNS + cur_col] = {print_attr, ch};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                    begin
                        line_feed();
                    end
                end
            end
            FUNC_CLEAR:
            begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            FUNC_READ:
            begin
                if (rr < ROWS && rc < COLUMNS)
                begin
                    r.cell_data = screen_cells[rr * COLUMNS + rc];
                end
            end
            default:
            begin
            end
        endcase
        r.row = RROW_W'(cur_row);
        r.col = RCOL_W'(cur_col);
        r.pos = POS_W'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    function logic [CHAR_W-1:0] plain_byte();
        logic [CHAR_W-1:0] ch;
        do
        begin
            ch = CHAR_W'($urandom_range(255));
        end
        while (ch == CHAR_NL || ch == CHAR_BS || ch == CHAR_CR);
        return ch;
    endfunction

    function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                             input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        char_code <= ch;
        read_row <= rr;
        read_col <= rc;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        expected_results.push_back(apply_item(f, ch, rr, rc));
        items_sent++;
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(FUNC_PUT, ch, RROW_W'($urandom_range(31)), RCOL_W'($urandom_range(127)));
    endtask

    task automatic read_cell(input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
        send_item(FUNC_READ, CHAR_W'($urandom_range(255)), rr, rc);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        print_attr = value;
    endtask

    task automatic test_reset_contents();
        read_cell(5'd0, 7'd0);
        read_cell(RROW_W'(ROWS - 1), RCOL_W'(COLUMNS - 1));
        read_cell(5'd12, 7'd40);
    endtask

    task automatic test_control_bytes();
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CHAR_BS);
        read_cell(5'd0, 7'd1);
        put_char(CHAR_BS);
        put_char(CHAR_BS);
        put_char(8'h41);
        put_char(CHAR_CR);
        put_char(CHAR_NL);
    endtask

    task automatic test_unused_and_out_of_grid();
        send_item(FUNC_NONE, 8'hFF, 5'd31, 7'd127);
        read_cell(RROW_W'(ROWS), 7'd0);
        read_cell(5'd0, RCOL_W'(COLUMNS));
        read_cell(5'd31, 7'd127);
    endtask

    task automatic test_clear();
        send_item(FUNC_CLEAR, 8'hFF, 5'd31, 7'd127);
        read_cell(5'd0, 7'd0);
        wait_drained();
    endtask

    task automatic test_attribute_extremes();
        write_attribute(8'hFF);
        put_char(8'h7E);
        read_cell(5'd0, 7'd0);
        wait_drained();
        write_attribute(8'h00);
        put_char(8'h20);
        read_cell(5'd0, 7'd1);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned stop;
        int unsigned pick;
        int unsigned burst;
        int unsigned k;
        logic [RROW_W-1:0] rr;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                // a line of text, sometimes long enough to wrap
                burst = ($urandom_range(9) == 0) ? $urandom_range(81, 170) : $urandom_range(1, 60);
                for (k = 0; k < burst && items_sent < stop; k++)
                begin
                    put_char(plain_byte());
                end
                if ($urandom_range(1) == 1 && items_sent < stop)
                begin
                    put_char(CHAR_NL);
                end
            end
            else if (pick < 76)
            begin
                if ($urandom_range(3) == 0)
                begin
                    rr = RROW_W'($urandom_range(31));
                end
                else
                begin
                    k = $urandom_range(2);
                    rr = (cur_row > k) ? RROW_W'(cur_row - k) : '0;
                end
                read_cell(rr, ($urandom_range(7) == 0) ? RCOL_W'($urandom_range(127))
                                                       : RCOL_W'($urandom_range(COLUMNS - 1)));
            end
            else if (pick < 88)
            begin
                case ($urandom_range(2))
                    0: put_char(CHAR_NL);
                    1: put_char(CHAR_BS);
                    default: put_char(CHAR_CR);
                endcase
            end
            else if (pick < 93)
            begin
                burst = $urandom_range(1, 8);
                for (k = 0; k < burst && items_sent < stop; k++)
                begin
                    put_char(CHAR_BS);
                end
            end
            else if (pick < 95)
            begin
                send_item(FUNC_NONE, CHAR_W'($urandom_range(255)), RROW_W'($urandom_range(31)),
                          RCOL_W'($urandom_range(127)));
            end
            else if (pick < 96)
            begin
                send_item(FUNC_CLEAR, CHAR_W'($urandom_range(255)), RROW_W'($urandom_range(31)),
                          RCOL_W'($urandom_range(127)));
            end
            else if (pick < 98)
            begin
                wait_drained();
                case ($urandom_range(3))
                    0: write_attribute(8'h00);
                    1: write_attribute(8'hFF);
                    default: write_attribute(ATTR_W'($urandom_range(255)));
                endcase
            end
            else
            begin
                read_cell(RROW_W'(ROWS - 1), RCOL_W'($urandom_range(COLUMNS - 1)));
            end
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        term_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no item outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("cell_value", 32'(want.cell_data), 32'(cell_value));
                check_field("cursor_row", 32'(want.row), 32'(cursor_row));
                check_field("cursor_col", 32'(want.col), 32'(cursor_col));
                check_field("cursor_position", 32'(want.pos), 32'(cursor_position));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
        print_attr = ATTR_RESET;
        send_idle_pct = 14;
        recv_stall_pct = 52;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_contents();
        test_control_bytes();
        test_unused_and_out_of_grid();
        test_clear();
        test_attribute_extremes();

        write_attribute(ATTR_W'($urandom_range(255)));
        test_random_traffic(PHASE_ITEMS);
        send_idle_pct = 52;
        recv_stall_pct = 14;
        write_attribute(8'hFF);
        test_random_traffic(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_attribute(8'h00);
        test_random_traffic(PHASE_ITEMS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
